>>> design/vwr_pkg.sv
// ----------------------------------------------------------------------------
// Variable width rotator package
// Widths, width codes and helper functions shared by the rotator files.
// ----------------------------------------------------------------------------
`default_nettype none

package vwr_pkg;

    localparam int DATA_W  = 64;
    localparam int CODE_W  = 3;
    localparam int COUNT_W = 6;
    localparam int WIDTH_W = 7;

    localparam logic [CODE_W-1:0] WC_8  = 3'd0;
    localparam logic [CODE_W-1:0] WC_16 = 3'd1;
    localparam logic [CODE_W-1:0] WC_32 = 3'd2;
    localparam logic [CODE_W-1:0] WC_64 = 3'd3;
    localparam logic [CODE_W-1:0] WC_9  = 3'd4;
    localparam logic [CODE_W-1:0] WC_17 = 3'd5;
    localparam logic [CODE_W-1:0] WC_33 = 3'd6;

    localparam logic [DATA_W-1:0] MASK_8  = 64'h0000_0000_0000_00FF;
    localparam logic [DATA_W-1:0] MASK_16 = 64'h0000_0000_0000_FFFF;
    localparam logic [DATA_W-1:0] MASK_32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MASK_64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MASK_9  = 64'h0000_0000_0000_01FF;
    localparam logic [DATA_W-1:0] MASK_17 = 64'h0000_0000_0001_FFFF;
    localparam logic [DATA_W-1:0] MASK_33 = 64'h0000_0001_FFFF_FFFF;

    typedef logic [WIDTH_W-1:0] t_width;
    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [COUNT_W-1:0] t_count;

    // Unused code 7 decodes as the 64-bit width.
    function automatic t_width width_bits(input logic [CODE_W-1:0] code);
        t_width w;
        unique case (code)
            WC_8:    w = 7'd8;
            WC_16:   w = 7'd16;
            WC_32:   w = 7'd32;
            WC_9:    w = 7'd9;
            WC_17:   w = 7'd17;
            WC_33:   w = 7'd33;
            default: w = 7'd64;
        endcase
        return w;
    endfunction

    function automatic t_data width_mask(input logic [CODE_W-1:0] code);
        t_data m;
        unique case (code)
            WC_8:    m = MASK_8;
            WC_16:   m = MASK_16;
            WC_32:   m = MASK_32;
            WC_9:    m = MASK_9;
            WC_17:   m = MASK_17;
            WC_33:   m = MASK_33;
            default: m = MASK_64;
        endcase
        return m;
    endfunction

    // Count reduced modulo the width by repeated compare and subtract; the
    // narrowest width of eight needs at most seven steps for a 6-bit count.
    function automatic t_count reduce_count(input t_count cnt, input t_width w);
        t_width c;
        c = {1'b0, cnt};
        for (int i = 0; i < 7; i++) begin
            if (c >= w) begin
                c = c - w;
            end
        end
        return c[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/vwr_if.sv
// ----------------------------------------------------------------------------
// Variable width rotator channels
// Valid/ready channels for operand items and rotated result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface vwr_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [vwr_pkg::CODE_W-1:0]   width_code;
    logic [vwr_pkg::DATA_W-1:0]   value;
    logic [vwr_pkg::COUNT_W-1:0]  count;

    modport source (output valid, op, width_code, value, count, input ready);
    modport sink   (input valid, op, width_code, value, count, output ready);
endinterface

interface vwr_out_if;
    logic                         valid;
    logic                         ready;
    logic [vwr_pkg::DATA_W-1:0]   rotated;

    modport source (output valid, rotated, input ready);
    modport sink   (input valid, rotated, output ready);
endinterface

`default_nettype wire

>>> design/variable_width_rotator.sv
// ----------------------------------------------------------------------------
// Variable width rotator
// Rotates an operand left or right within 8, 9, 16, 17, 32, 33 or 64 bits.
// ----------------------------------------------------------------------------
//
//  Channel   Direction   Payload
//  i_in      sink        op, width_code, value, count
//  o_out     source      rotated
//
//  An item enters the input register, is rotated by one combinational pass
//  and lands in the result register, from which its result is offered.
//  One item is accepted every cycle while the output is taken.
//  A stalled output holds the result register, and the input register, if empty,
//  still takes one more item before ready drops. Reset empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_width_rotator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    vwr_in_if.sink     i_in,
    vwr_out_if.source  o_out
);

    logic                         r_in_valid;
    logic                         r_in_op;
    logic [vwr_pkg::CODE_W-1:0]   r_in_code;
    vwr_pkg::t_data               r_in_value;
    vwr_pkg::t_count              r_in_count;

    logic                         r_out_valid;
    vwr_pkg::t_data               r_out_rotated;
    vwr_pkg::t_data               n_rotated;

    logic                         out_free;
    logic                         in_free;

    vwr_pkg::t_width              width;
    vwr_pkg::t_data               mask;
    vwr_pkg::t_count              red_count;
    vwr_pkg::t_count              left_count;
    logic [2*vwr_pkg::DATA_W-1:0] shifted;
    logic [2*vwr_pkg::DATA_W-1:0] wrapped;

    assign out_free    = !r_out_valid || o_out.ready;
    assign in_free     = !r_in_valid || out_free;
    assign i_in.ready  = in_free;
    assign o_out.valid = r_out_valid;
    assign o_out.rotated = r_out_rotated;

    // A right rotation is done as a left rotation by the width minus the count.
    always_comb begin
        width     = vwr_pkg::width_bits(r_in_code);
        mask      = vwr_pkg::width_mask(r_in_code);
        red_count = vwr_pkg::reduce_count(r_in_count, width);
        if (r_in_op && (red_count != '0)) begin
            left_count = vwr_pkg::COUNT_W'(width - {1'b0, red_count});
        end else begin
            left_count = red_count;
        end
        shifted   = {{vwr_pkg::DATA_W{1'b0}}, (r_in_value & mask)} << left_count;
        wrapped   = shifted >> width;
        n_rotated = (shifted[vwr_pkg::DATA_W-1:0] | wrapped[vwr_pkg::DATA_W-1:0]) & mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_free) begin
            r_in_op    <= i_in.op;
            r_in_code  <= i_in.width_code;
            r_in_value <= i_in.value;
            r_in_count <= i_in.count;
        end
        if (r_in_valid && out_free) begin
            r_out_rotated <= n_rotated;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Variable width rotator testbench
// Drives operand items through the rotator with random idling and stalls,
// predicts each rotated result and checks it in order against the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import vwr_pkg::*;

    localparam logic DIR_LEFT  = 1'b0;
    localparam logic DIR_RIGHT = 1'b1;
    localparam logic [CODE_W-1:0] WC_SPARE = 3'd7;
    localparam logic [CODE_W-1:0] ALL_CODES [8] =
        '{WC_8, WC_16, WC_32, WC_64, WC_9, WC_17, WC_33, WC_SPARE};

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_LEN     = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 24;

    typedef struct packed {
        logic              op;
        logic [CODE_W-1:0] width_code;
        t_data             value;
        t_count            count;
    } operand_t;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    vwr_in_if  in_if ();
    vwr_out_if out_if ();

    variable_width_rotator dut (
        .i_clk   (i_clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    operand_t operand_q [$];
    t_data    rotated_q [$];
    operand_t offered;
    int       items_queued = 0;
    int       results_done = 0;
    int       errors       = 0;
    int       cycles       = 0;
    int       src_idle_pct = IDLE_PCT;
    int       snk_idle_pct = IDLE_PCT;
    int       hold_left    = 0;
    logic     hold_tgl     = 1'b0;
    logic     hold_seen    = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_data rotated_value(operand_t it);
        int unsigned w;
        int unsigned c;
        t_data       m;
        t_data       x;
        case (it.width_code)
            WC_8: begin
                w = 8;  m = MASK_8;
            end
            WC_16: begin
                w = 16; m = MASK_16;
            end
            WC_32: begin
                w = 32; m = MASK_32;
            end
            WC_9: begin
                w = 9;  m = MASK_9;
            end
            WC_17: begin
                w = 17; m = MASK_17;
            end
            WC_33: begin
                w = 33; m = MASK_33;
            end
            default: begin
                w = 64; m = MASK_64;
            end
        endcase
        x = it.value & m;
        c = it.count % w;
        if (c == 0) begin
            return x;
        end
        if (it.op == DIR_LEFT) begin
            return ((x << c) | (x >> (w - c))) & m;
        end
        return ((x >> c) | (x << (w - c))) & m;
    endfunction

    task automatic report_mismatch(string what, t_data got, t_data want);
        $display("mismatch at cycle %0d: %s, got %h, expected %h", cycles, what, got, want);
        errors++;
    endtask

    task automatic add_operand(logic op, logic [CODE_W-1:0] code, t_data value, t_count count);
        operand_t it;
        it.op         = op;
        it.width_code = code;
        it.value      = value;
        it.count      = count;
        operand_q.push_back(it);
        items_queued++;
    endtask

    task automatic add_random(int n);
        t_data v;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0:       v = '1;
                1:       v = t_data'(1) << $urandom_range(0, DATA_W - 1);
                2:       v = ~(t_data'(1) << $urandom_range(0, DATA_W - 1));
                default: v = {$urandom, $urandom};
            endcase
            add_operand(1'($urandom_range(0, 1)), ALL_CODES[$urandom_range(0, 7)], v,
                        t_count'($urandom_range(0, 63)));
        end
    endtask

    task automatic wait_drained();
        wait (results_done == items_queued);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : driver
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                rotated_q.push_back(rotated_value(offered));
            end
            if (!in_if.valid || in_if.ready) begin
                if (operand_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    offered = operand_q.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.op         <= offered.op;
                    in_if.width_code <= offered.width_code;
                    in_if.value      <= offered.value;
                    in_if.count      <= offered.count;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : hold_counter
        if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_LEN;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_data want;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (rotated_q.size() == 0) begin
                    report_mismatch("rotated result with no item waiting", out_if.rotated, '0);
                end else begin
                    want = rotated_q.pop_front();
                    if (out_if.rotated !== want) begin
                        report_mismatch("rotated", out_if.rotated, want);
                    end
                end
                results_done++;
            end
            out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        in_if.valid      = 1'b0;
        in_if.op         = DIR_LEFT;
        in_if.width_code = WC_8;
        in_if.value      = '0;
        in_if.count      = '0;
        out_if.ready     = 1'b0;

        foreach (ALL_CODES[i]) begin
            add_operand(DIR_LEFT, ALL_CODES[i], 64'hF0E1_D2C3_B4A5_9687, 6'd1);
        end
        foreach (ALL_CODES[i]) begin
            add_operand(DIR_RIGHT, ALL_CODES[i], 64'h0123_4567_89AB_CDEF, 6'd63);
        end
        // Counts that reduce to zero return the masked operand; the last item rotates a zero operand.
        add_operand(DIR_LEFT,  WC_9,  '1, 6'd63);
        add_operand(DIR_LEFT,  WC_8,  '1, 6'd0);
        add_operand(DIR_RIGHT, WC_16, 64'hA5A5_A5A5_A5A5_A5A5, 6'd48);
        add_operand(DIR_RIGHT, WC_33, '1, 6'd33);
        add_operand(DIR_LEFT,  WC_17, 64'hFFFF_0000_0001_2345, 6'd34);
        add_operand(DIR_LEFT,  WC_64, '0, 6'd63);

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        wait_drained();
        add_random(400);

        // Receiver holds off while the sender streams without gaps.
        wait_drained();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_tgl     = ~hold_tgl;
        add_random(200);

        wait_drained();
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
        add_random(600);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rotated_q.size() != 0) begin
            report_mismatch("rotated results never arrived", '0, rotated_q[0]);
        end
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
